FILE: hdl/vmeu_pkg.sv
// Package of shared types and constants for the variable machine execute unit.
`timescale 1ns / 1ps
`default_nettype none
package vmeu_pkg;
	localparam int VAR_COUNT = 26;
	localparam int VIDX_W = 5;
	// Program depth; next addresses wrap modulo this power of two.
	localparam int PROGRAM_DEPTH = 1024;

	typedef enum logic [3:0] {
		OP_SET   = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_IFGT  = 4'd5,
		OP_IFEQ  = 4'd6,
		OP_ELSE  = 4'd7,
		OP_ENDIF = 4'd8,
		OP_GOTO  = 4'd9,
		OP_CLEAR = 4'd10
	} opcode_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDEF = 2'd1;
	localparam logic [1:0] ST_DIVZ  = 2'd2;

	// One decoded instruction as it travels from the front part to the back part.
	typedef struct packed {
		logic [3:0]         opcode;
		logic [VIDX_W-1:0]  dest_var;
		logic               a_is_var;
		logic [VIDX_W-1:0]  a_var;
		logic [31:0]        a_imm;
		logic               b_is_var;
		logic [VIDX_W-1:0]  b_var;
		logic [31:0]        b_imm;
		logic [9:0]         address;
		logic [9:0]         jump_target;
		logic [10:0]        jump_offset;
	} instr_t;

	typedef struct packed {
		logic [9:0]  next_address;
		logic [1:0]  status;
		logic [10:0] fault_line;
		logic [31:0] written_value;
		logic        cond_true;
	} result_t;
endpackage
`default_nettype wire

FILE: hdl/vmeu_queue.sv
// Two-entry instruction queue between the front part and the back part.
`timescale 1ns / 1ps
`default_nettype none
module vmeu_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  vmeu_pkg::instr_t      in_data,
	output logic                  out_valid,
	input  wire                   out_ready,
	output vmeu_pkg::instr_t      out_data
);
	vmeu_pkg::instr_t mem_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;

	logic push;
	logic pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = mem_q[rptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

FILE: hdl/vmeu_divider.sv
// Iterative signed 32-bit divider, one quotient bit a cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module vmeu_divider (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [31:0] dividend,
	input  wire  [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;

	logic [32:0] trial;
	logic [31:0] shifted;

	assign shifted = {rem_q[30:0], quo_q[31]};
	assign trial   = {1'b0, shifted} - {1'b0, dvs_q};
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= 6'd0;
			rem_q  <= 32'd0;
			quo_q  <= 32'd0;
			dvs_q  <= 32'd0;
			neg_q  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
				rem_q  <= 32'd0;
				quo_q  <= dividend[31] ? (32'd0 - dividend) : dividend;
				dvs_q  <= divisor[31] ? (32'd0 - divisor) : divisor;
				neg_q  <= dividend[31] ^ divisor[31];
			end else if (busy_q) begin
				// Quotient bits shift in at the bottom as dividend bits leave the top.
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/vmeu_back.sv
// Back part: operand fetch, execution, variable file update and result register.
`timescale 1ns / 1ps
`default_nettype none
module vmeu_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  vmeu_pkg::instr_t   in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output vmeu_pkg::result_t  out_data
);
	localparam int AW = $clog2(vmeu_pkg::PROGRAM_DEPTH);

	typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DIV, S_DONE, S_MUL} state_t;

	state_t                      state_q;
	vmeu_pkg::instr_t            ins_q;
	logic [31:0]                 vals_q [vmeu_pkg::VAR_COUNT];
	logic [vmeu_pkg::VAR_COUNT-1:0] def_q;
	logic [31:0]                 a_q;
	logic [31:0]                 b_q;
	logic                        undef_q;
	logic [31:0]                 mul_s1;

	logic [31:0] a_val;
	logic [31:0] b_val;
	logic        a_ok;
	logic        b_ok;
	logic        div_start;
	logic        div_done;
	logic [31:0] div_quo;
	logic        mul_wait;
	logic        finish;

	vmeu_pkg::result_t res;
	logic [31:0]       wr_val;
	logic              do_write;

	vmeu_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (a_q),
		.divisor  (b_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	// Operand fetch from the variable file; an index beyond Z reads as undefined.
	always_comb begin
		a_ok  = 1'b1;
		b_ok  = 1'b1;
		a_val = ins_q.a_imm;
		b_val = ins_q.b_imm;
		if (ins_q.a_is_var) begin
			if (ins_q.a_var < vmeu_pkg::VIDX_W'(vmeu_pkg::VAR_COUNT)) begin
				a_ok  = def_q[ins_q.a_var];
				a_val = vals_q[ins_q.a_var];
			end else begin
				a_ok = 1'b0;
			end
		end
		if (ins_q.b_is_var) begin
			if (ins_q.b_var < vmeu_pkg::VIDX_W'(vmeu_pkg::VAR_COUNT)) begin
				b_ok  = def_q[ins_q.b_var];
				b_val = vals_q[ins_q.b_var];
			end else begin
				b_ok = 1'b0;
			end
		end
	end

	assign div_start = (state_q == S_EXEC) && (ins_q.opcode == vmeu_pkg::OP_DIV)
		&& !undef_q && (b_q != 32'd0);

	// The product is registered, so a multiply passes through S_MUL before it finishes.
	assign mul_wait = (ins_q.opcode == vmeu_pkg::OP_MUL) && !undef_q;
	assign finish   = ((state_q == S_EXEC) && !div_start && !mul_wait) ||
		(state_q == S_MUL) || ((state_q == S_DIV) && div_done);

	function automatic logic [9:0] wrap(input logic [11:0] a);
		logic [AW-1:0] m;
		begin
			m = a[AW-1:0];
			wrap = 10'(m);
		end
	endfunction

	// Result and write-back decision once the operands are held.
	always_comb begin
		logic [11:0] addr1;
		logic [11:0] tgt1;
		logic        cond;
		addr1    = 12'(ins_q.address) + 12'd1;
		tgt1     = 12'(ins_q.jump_target) + 12'd1;
		cond     = 1'b0;
		wr_val   = 32'd0;
		do_write = 1'b0;
		res.next_address  = wrap(addr1);
		res.status        = vmeu_pkg::ST_OK;
		res.fault_line    = 11'd0;
		res.written_value = 32'd0;
		res.cond_true     = 1'b0;
		unique case (ins_q.opcode)
			vmeu_pkg::OP_SET: begin
				wr_val = a_q; do_write = 1'b1;
			end
			vmeu_pkg::OP_ADD: begin
				wr_val = a_q + b_q; do_write = 1'b1;
			end
			vmeu_pkg::OP_SUB: begin
				wr_val = a_q - b_q; do_write = 1'b1;
			end
			vmeu_pkg::OP_MUL: begin
				wr_val = mul_s1; do_write = 1'b1;
			end
			vmeu_pkg::OP_DIV: begin
				if (b_q == 32'd0) begin
					res.status = vmeu_pkg::ST_DIVZ;
				end else begin
					wr_val = div_quo; do_write = 1'b1;
				end
			end
			vmeu_pkg::OP_IFGT, vmeu_pkg::OP_IFEQ: begin
				cond = (ins_q.opcode == vmeu_pkg::OP_IFGT) ?
					($signed(a_q) > $signed(b_q)) : (a_q == b_q);
				res.cond_true = cond;
				if (!cond) res.next_address = wrap(tgt1);
			end
			vmeu_pkg::OP_ELSE: res.next_address = wrap(12'(ins_q.jump_target));
			vmeu_pkg::OP_GOTO: res.next_address =
				wrap(12'(ins_q.address) + 12'(signed'(ins_q.jump_offset)));
			default: ;
		endcase
		if (undef_q && ins_q.opcode <= vmeu_pkg::OP_IFEQ) begin
			res.status        = vmeu_pkg::ST_UNDEF;
			res.cond_true     = 1'b0;
			do_write          = 1'b0;
		end
		if (res.status != vmeu_pkg::ST_OK) begin
			do_write         = 1'b0;
			res.next_address = wrap(12'(ins_q.address));
			res.fault_line   = (res.status == vmeu_pkg::ST_UNDEF) ?
				11'(ins_q.address) + 11'd1 : 11'(ins_q.address);
		end
		if (do_write && ins_q.dest_var >= vmeu_pkg::VIDX_W'(vmeu_pkg::VAR_COUNT))
			do_write = 1'b0;
		if (do_write) res.written_value = wr_val;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) ins_q <= in_data;
		mul_s1 <= a_q * b_q;
		if (state_q == S_IDLE) begin
			a_q     <= 32'd0;
			b_q     <= 32'd0;
		end
		if (finish) begin
			out_data <= res;
			if (do_write) vals_q[ins_q.dest_var] <= wr_val;
		end
		if (state_q == S_DONE) begin
			a_q     <= a_val;
			b_q     <= (ins_q.opcode == vmeu_pkg::OP_SET) ? 32'd0 : b_val;
			undef_q <= !a_ok || (ins_q.opcode != vmeu_pkg::OP_SET && !b_ok);
		end
	end

	// S_DONE doubles as the operand fetch state between accept and execution.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			def_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) state_q <= S_DONE;
				S_DONE: state_q <= S_EXEC;
				S_EXEC: begin
					if (div_start) begin
						state_q <= S_DIV;
					end else if (mul_wait) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MUL: state_q <= S_IDLE;
				S_DIV: if (div_done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (finish) begin
				out_valid <= 1'b1;
				if (ins_q.opcode == vmeu_pkg::OP_CLEAR) def_q <= '0;
				if (do_write) def_q[ins_q.dest_var] <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: hdl/vmeu_front.sv
// Front part: accepts instruction items from the stream and unpacks their fields.
`timescale 1ns / 1ps
`default_nettype none
module vmeu_front (
	input  wire               s_tvalid,
	output logic              s_tready,
	input  wire  [119:0]      s_tdata,
	output logic              q_valid,
	input  wire               q_ready,
	output vmeu_pkg::instr_t  q_data
);
	assign q_valid = s_tvalid;
	assign s_tready = q_ready;
	always_comb begin
		q_data.opcode      = s_tdata[3:0];
		q_data.dest_var    = s_tdata[8:4];
		q_data.a_is_var    = s_tdata[9];
		q_data.a_var       = s_tdata[14:10];
		q_data.a_imm       = s_tdata[46:15];
		q_data.b_is_var    = s_tdata[47];
		q_data.b_var       = s_tdata[52:48];
		q_data.b_imm       = s_tdata[84:53];
		q_data.address     = s_tdata[94:85];
		q_data.jump_target = s_tdata[104:95];
		q_data.jump_offset = s_tdata[115:105];
	end
endmodule
`default_nettype wire

FILE: hdl/variable_machine_execute_unit.sv
// Top level of the variable machine execute unit.
`timescale 1ns / 1ps
`default_nettype none
// One instruction item at a time passes a two-entry queue into the back part, where it
// passes operand fetch and execution before its result is registered. Multiply also
// waits for its registered product, and divide for the divider, which retires one
// quotient bit a cycle. The back part takes its next item only once the result has
// been taken. Variables reset undefined, and next addresses wrap modulo 1024.
module variable_machine_execute_unit (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// opcode, dest_var, a_is_var, a_var, a_imm, b_is_var, b_var, b_imm,
	// address, jump_target, jump_offset
	input  wire  [119:0] s_tdata,
	output logic         m_tvalid,
	input  wire          m_tready,
	// next_address, status, fault_line, written_value, cond_true
	output logic [55:0]  m_tdata
);
	logic              f_valid, f_ready, q_valid, q_ready;
	vmeu_pkg::instr_t  f_data, q_data;
	vmeu_pkg::result_t r;

	function automatic logic [55:0] pack_pad(input vmeu_pkg::result_t x);
		pack_pad = {x.cond_true, x.written_value, x.fault_line, x.status, x.next_address};
	endfunction

	vmeu_front u_front (
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
	);
	vmeu_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
	);
	vmeu_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_data(r)
	);

	assign m_tdata = pack_pad(r);

`ifndef SYNTH
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[11:10] != 2'd3)) else $error("bad status");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

FILE: dv/tb_variable_machine_execute_unit.sv
// Testbench for the variable machine execute unit: directed and random instructions.
`timescale 1ns / 1ps
module tb_variable_machine_execute_unit;
	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// opcode, dest_var, a_is_var, a_var, a_imm, b_is_var, b_var, b_imm,
	// address, jump_target, jump_offset
	logic [119:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// next_address, status, fault_line, written_value, cond_true
	logic [55:0]  m_tdata;

	variable_machine_execute_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Predictor state: the variables and their defined flags.
	logic [31:0]        shadow_val [vmeu_pkg::VAR_COUNT];
	logic               shadow_def [vmeu_pkg::VAR_COUNT];
	vmeu_pkg::result_t  pending_results [$];
	int                 error_count = 0;
	int                 op_seen [16];
	int                 results_checked = 0;
	bit                 quiet;
	bit                 pressure_go;
	bit                 pressure_done = 1'b0;
	int                 hold_left = 0;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d results still outstanding", pending_results.size());
		$display("Simulation FAILED");
		$finish;
	end

	task automatic report_mismatch(input string field, input longint got, input longint want);
		error_count++;
		$display("Mismatch on %s at %0t: got %0h, expected %0h", field, $time, got, want);
	endtask

	function automatic logic [119:0] pack_instr(input vmeu_pkg::instr_t ins);
		return {4'd0, ins.jump_offset, ins.jump_target, ins.address, ins.b_imm, ins.b_var,
			ins.b_is_var, ins.a_imm, ins.a_var, ins.a_is_var, ins.dest_var, ins.opcode};
	endfunction

	function automatic bit fetch_operand(input logic is_var, input logic [4:0] idx,
			input logic [31:0] imm, output logic [31:0] val);
		val = imm;
		if (is_var) begin
			if (idx >= vmeu_pkg::VAR_COUNT || !shadow_def[idx]) return 1'b0;
			val = shadow_val[idx];
		end
		return 1'b1;
	endfunction

	function automatic vmeu_pkg::result_t execute_instr(input vmeu_pkg::instr_t ins);
		vmeu_pkg::result_t res;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] r;
		bit          ok_a;
		bit          ok_b;
		bit          do_write;
		res = '0;
		r = '0;
		do_write = 1'b0;
		res.next_address = ins.address + 10'd1;
		res.status = vmeu_pkg::ST_OK;
		ok_a = fetch_operand(ins.a_is_var, ins.a_var, ins.a_imm, a);
		ok_b = fetch_operand(ins.b_is_var, ins.b_var, ins.b_imm, b);
		case (ins.opcode)
			vmeu_pkg::OP_SET: begin
				if (!ok_a) res.status = vmeu_pkg::ST_UNDEF;
				else begin
					r = a;
					do_write = 1'b1;
				end
			end
			vmeu_pkg::OP_ADD, vmeu_pkg::OP_SUB, vmeu_pkg::OP_MUL, vmeu_pkg::OP_DIV,
			vmeu_pkg::OP_IFGT, vmeu_pkg::OP_IFEQ: begin
				if (!ok_a || !ok_b) res.status = vmeu_pkg::ST_UNDEF;
				else if (ins.opcode == vmeu_pkg::OP_IFGT || ins.opcode == vmeu_pkg::OP_IFEQ)
				begin
					res.cond_true = (ins.opcode == vmeu_pkg::OP_IFGT) ?
						($signed(a) > $signed(b)) : (a == b);
					if (!res.cond_true) res.next_address = ins.jump_target + 10'd1;
				end else if (ins.opcode == vmeu_pkg::OP_DIV && b == 32'd0)
					res.status = vmeu_pkg::ST_DIVZ;
				else begin
					do_write = 1'b1;
					case (ins.opcode)
						vmeu_pkg::OP_ADD: r = a + b;
						vmeu_pkg::OP_SUB: r = a - b;
						vmeu_pkg::OP_MUL: r = a * b;
						default: begin
							// The most negative value over minus one wraps onto itself.
							if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) r = a;
							else r = $signed(a) / $signed(b);
						end
					endcase
				end
			end
			vmeu_pkg::OP_ELSE: res.next_address = ins.jump_target;
			vmeu_pkg::OP_GOTO: res.next_address = ins.address + ins.jump_offset[9:0];
			vmeu_pkg::OP_CLEAR: begin
				for (int i = 0; i < vmeu_pkg::VAR_COUNT; i++) begin
					shadow_def[i] = 1'b0;
					shadow_val[i] = '0;
				end
			end
			default: ;
		endcase
		if (res.status == vmeu_pkg::ST_UNDEF) begin
			res.fault_line = {1'b0, ins.address} + 11'd1;
			res.next_address = ins.address;
			res.cond_true = 1'b0;
		end else if (res.status == vmeu_pkg::ST_DIVZ) begin
			res.fault_line = {1'b0, ins.address};
			res.next_address = ins.address;
		end else if (do_write && ins.dest_var < vmeu_pkg::VAR_COUNT) begin
			shadow_val[ins.dest_var] = r;
			shadow_def[ins.dest_var] = 1'b1;
			res.written_value = r;
		end
		return res;
	endfunction

	// Offers one item, idling at random cycles before it unless idling is switched off.
	task automatic send_instr(input vmeu_pkg::instr_t ins);
		logic [119:0] word;
		word = pack_instr(ins);
		while (!quiet && $urandom_range(99) < 38) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(execute_instr(ins));
		op_seen[ins.opcode]++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else begin
			if (pressure_go && !pressure_done) begin
				hold_left = 400;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 38);
		end
	end

	always @(posedge clk) begin
		vmeu_pkg::result_t got;
		vmeu_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.next_address  = m_tdata[9:0];
			got.status        = m_tdata[11:10];
			got.fault_line    = m_tdata[22:12];
			got.written_value = m_tdata[54:23];
			got.cond_true     = m_tdata[55];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 0);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got.next_address != want.next_address)
					report_mismatch("next_address", got.next_address, want.next_address);
				if (got.status != want.status)
					report_mismatch("status", got.status, want.status);
				if (got.fault_line != want.fault_line)
					report_mismatch("fault_line", got.fault_line, want.fault_line);
				if (got.written_value != want.written_value)
					report_mismatch("written_value", got.written_value, want.written_value);
				if (got.cond_true != want.cond_true)
					report_mismatch("cond_true", got.cond_true, want.cond_true);
			end
		end
	end

	function automatic vmeu_pkg::instr_t make_instr(input logic [3:0] op,
			input logic [4:0] dst,
			input logic av, input logic [4:0] ai, input logic [31:0] aimm,
			input logic bv, input logic [4:0] bi, input logic [31:0] bimm);
		vmeu_pkg::instr_t ins;
		ins.opcode = op;
		ins.dest_var = dst;
		ins.a_is_var = av;
		ins.a_var = ai;
		ins.a_imm = aimm;
		ins.b_is_var = bv;
		ins.b_var = bi;
		ins.b_imm = bimm;
		ins.address = 10'($urandom);
		ins.jump_target = 10'($urandom);
		ins.jump_offset = 11'($urandom);
		return ins;
	endfunction

	task automatic test_undefined_reads();
		send_instr(make_instr(vmeu_pkg::OP_SET, 5'd0, 1'b1, 5'd3, 32'd0, 1'b0, 5'd0, 32'd0));
		send_instr(make_instr(vmeu_pkg::OP_SET, 5'd1, 1'b0, 5'd0, 32'h7FFF_FFFF, 1'b0, 5'd0,
			32'd0));
		// First operand undefined wins over a defined second operand.
		send_instr(make_instr(vmeu_pkg::OP_ADD, 5'd2, 1'b1, 5'd9, 32'd0, 1'b1, 5'd1, 32'd0));
		send_instr(make_instr(vmeu_pkg::OP_IFGT, 5'd2, 1'b1, 5'd1, 32'd0, 1'b1, 5'd31,
			32'd0));
		send_instr(make_instr(vmeu_pkg::OP_SET, 5'd31, 1'b0, 5'd0, 32'h1234_5678, 1'b0, 5'd0,
			32'd0));
		send_instr(make_instr(vmeu_pkg::OP_SET, 5'd27, 1'b1, 5'd26, 32'd0, 1'b0, 5'd0, 32'd0));
	endtask

	task automatic test_arith_extremes();
		send_instr(make_instr(vmeu_pkg::OP_SET, 5'd25, 1'b0, 5'd0, 32'h8000_0000, 1'b1, 5'd7,
			32'd5));
		send_instr(make_instr(vmeu_pkg::OP_ADD, 5'd2, 1'b1, 5'd1, 32'd0, 1'b0, 5'd0, 32'd1));
		send_instr(make_instr(vmeu_pkg::OP_SUB, 5'd3, 1'b1, 5'd25, 32'd0, 1'b0, 5'd0, 32'd1));
		send_instr(make_instr(vmeu_pkg::OP_MUL, 5'd4, 1'b1, 5'd1, 32'd0, 1'b1, 5'd1, 32'd0));
		send_instr(make_instr(vmeu_pkg::OP_MUL, 5'd5, 1'b0, 5'd0, 32'hFFFF_FFFF, 1'b1, 5'd25,
			32'd0));
	endtask

	task automatic test_division();
		send_instr(make_instr(vmeu_pkg::OP_DIV, 5'd6, 1'b1, 5'd25, 32'd0, 1'b0, 5'd0,
			32'hFFFF_FFFF));
		send_instr(make_instr(vmeu_pkg::OP_DIV, 5'd7, 1'b0, 5'd0, 32'hFFFF_FFF9, 1'b0, 5'd0,
			32'd2));
		send_instr(make_instr(vmeu_pkg::OP_DIV, 5'd8, 1'b0, 5'd0, 32'd7, 1'b0, 5'd0,
			32'hFFFF_FFFE));
		send_instr(make_instr(vmeu_pkg::OP_DIV, 5'd9, 1'b1, 5'd1, 32'd0, 1'b0, 5'd0, 32'd0));
	endtask

	task automatic test_branches();
		vmeu_pkg::instr_t ins;
		send_instr(make_instr(vmeu_pkg::OP_IFGT, 5'd0, 1'b1, 5'd1, 32'd0, 1'b1, 5'd25,
			32'd0));
		send_instr(make_instr(vmeu_pkg::OP_IFGT, 5'd0, 1'b1, 5'd25, 32'd0, 1'b1, 5'd1,
			32'd0));
		send_instr(make_instr(vmeu_pkg::OP_IFEQ, 5'd0, 1'b0, 5'd0, 32'd5, 1'b0, 5'd0, 32'd5));
		ins = make_instr(vmeu_pkg::OP_IFEQ, 5'd0, 1'b0, 5'd0, 32'd5, 1'b0, 5'd0, 32'd6);
		ins.jump_target = 10'h3FF;
		send_instr(ins);
		ins = make_instr(vmeu_pkg::OP_ELSE, 5'd0, 1'b0, 5'd0, 32'd0, 1'b0, 5'd0, 32'd0);
		send_instr(ins);
		ins = make_instr(vmeu_pkg::OP_ENDIF, 5'd0, 1'b0, 5'd0, 32'd0, 1'b0, 5'd0, 32'd0);
		ins.address = 10'h3FF;
		send_instr(ins);
	endtask

	task automatic test_goto_clear_unused();
		vmeu_pkg::instr_t ins;
		ins = make_instr(vmeu_pkg::OP_GOTO, 5'd0, 1'b0, 5'd0, 32'd0, 1'b0, 5'd0, 32'd0);
		ins.address = 10'd2;
		ins.jump_offset = -11'sd1023;
		send_instr(ins);
		ins.jump_offset = 11'd0;
		send_instr(ins);
		send_instr(make_instr(4'd15, 5'd0, 1'b1, 5'd0, 32'd0, 1'b1, 5'd0, 32'd0));
		send_instr(make_instr(vmeu_pkg::OP_CLEAR, 5'd0, 1'b0, 5'd0, 32'd0, 1'b0, 5'd0, 32'd0));
		send_instr(make_instr(vmeu_pkg::OP_SET, 5'd0, 1'b1, 5'd1, 32'd0, 1'b0, 5'd0, 32'd0));
	endtask

	function automatic logic [4:0] pick_index();
		int tries;
		logic [4:0] idx;
		if ($urandom_range(99) < 5) return 5'($urandom);
		for (tries = 0; tries < 8; tries++) begin
			idx = 5'($urandom_range(vmeu_pkg::VAR_COUNT - 1));
			if (shadow_def[idx]) return idx;
		end
		return idx;
	endfunction

	function automatic logic [31:0] pick_imm();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return $urandom_range(0, 8);
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed instructions over defined variables, with a little noise.
	task automatic test_random(input int count);
		vmeu_pkg::instr_t ins;
		int     sel;
		for (int n = 0; n < count; n++) begin
			quiet = (n >= count / 3 && n < count / 3 + 200);
			sel = $urandom_range(99);
			if (sel < 2) ins.opcode = vmeu_pkg::OP_CLEAR;
			else if (sel < 5) ins.opcode = 4'($urandom_range(11, 15));
			else if (sel < 12) ins.opcode = vmeu_pkg::OP_DIV;
			else ins.opcode = 4'($urandom_range(0, 9));
			ins.dest_var = ($urandom_range(99) < 4) ? 5'($urandom) : 5'($urandom_range(25));
			ins.a_is_var = ($urandom_range(99) < 60);
			ins.a_var = ins.a_is_var ? pick_index() : 5'($urandom);
			ins.a_imm = pick_imm();
			ins.b_is_var = ($urandom_range(99) < 60);
			ins.b_var = ins.b_is_var ? pick_index() : 5'($urandom);
			ins.b_imm = pick_imm();
			ins.address = 10'($urandom);
			ins.jump_target = 10'($urandom);
			ins.jump_offset = 11'($urandom);
			send_instr(ins);
		end
		quiet = 1'b0;
	endtask

	// The receiver holds off for a long stretch while items keep coming.
	task automatic test_back_pressure();
		pressure_go = 1'b1;
		test_random(20);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		quiet = 1'b0;
		pressure_go = 1'b0;
		for (int i = 0; i < 16; i++) op_seen[i] = 0;
		for (int i = 0; i < vmeu_pkg::VAR_COUNT; i++) begin
			shadow_val[i] = '0;
			shadow_def[i] = 1'b0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_undefined_reads();
		test_arith_extremes();
		test_division();
		test_branches();
		test_goto_clear_unused();
		test_back_pressure();
		test_random(860);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("Checked %0d results: set %0d, arithmetic %0d, divide %0d, branches %0d,",
			results_checked, op_seen[vmeu_pkg::OP_SET], op_seen[vmeu_pkg::OP_ADD] +
			op_seen[vmeu_pkg::OP_SUB] + op_seen[vmeu_pkg::OP_MUL], op_seen[vmeu_pkg::OP_DIV],
			op_seen[vmeu_pkg::OP_IFGT] + op_seen[vmeu_pkg::OP_IFEQ] +
			op_seen[vmeu_pkg::OP_ELSE] + op_seen[vmeu_pkg::OP_ENDIF]);
		$display("goto %0d, clear %0d, long receiver stall included, %0d mismatches",
			op_seen[vmeu_pkg::OP_GOTO], op_seen[vmeu_pkg::OP_CLEAR], error_count);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
